FILE: src/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg: shared constants for the serial packet deframer
// Frame marker, byte class codes, configuration register indexes, widths.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CLS_W      = 2;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_OUT_W  = 16;
  localparam int unsigned COUNT_W_DEFAULT = 16;

  localparam logic [BYTE_W-1:0] FRAME_START = 8'hff;

  // byte classes
  localparam logic [CLS_W-1:0] CLS_TEXT     = 2'd0;
  localparam logic [CLS_W-1:0] CLS_HEADER   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_PAYLOAD  = 2'd2;
  localparam logic [CLS_W-1:0] CLS_REJECTED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PACKET_ENABLE = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH    = 4'd1;

  // result word layout
  localparam int unsigned OUT_TDATA_W = BYTE_W + LEN_W + LEN_W + 2 * CNT_OUT_W;
  localparam int unsigned OUT_TUSER_W = CLS_W + 1;

endpackage

FILE: src/serial_packet_deframer.sv
// ----------------------------------------------------------------------------
// serial_packet_deframer
// Finds 0xff / len hi / len lo / checksum / payload frames in a byte stream,
// tags every byte with its class and keeps good/bad frame counters.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata[7:0] rx_byte
//  m_axis   | out       | tdata: out_byte, payload_index, frame_length,
//           |           |        good_frames, bad_frames; tuser: byte_class,
//           |           |        checksum_good; tlast: frame_done
//  cfg      | in        | addr: register index, data: value
//
// One byte per cycle unless stalled. Each byte is decoded in the cycle it is
// accepted and its result lands in the output register, shown the next cycle.
// The input is taken whenever the output register is empty or being drained,
// so a held result stalls the input only while m_axis_tready_i is low.
// Reset clears the frame state, the counters and both configuration registers.
module serial_packet_deframer #(
  parameter int unsigned COUNT_WIDTH = spd_pkg::COUNT_W_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // rx_byte[7:0]
  input  logic [spd_pkg::BYTE_W-1:0]          s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // out_byte[7:0], payload_index[23:8], frame_length[39:24],
  // good_frames[55:40], bad_frames[71:56]
  output logic [spd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // byte_class[1:0], checksum_good[2]
  output logic [spd_pkg::OUT_TUSER_W-1:0]     m_axis_tuser_o,
  output logic                                m_axis_tlast_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [spd_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [spd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned LEN_W  = spd_pkg::LEN_W;
  localparam int unsigned BYTE_W = spd_pkg::BYTE_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LEN_HI  = 3'd1;
  localparam logic [2:0] ST_LEN_LO  = 3'd2;
  localparam logic [2:0] ST_CSUM    = 3'd3;
  localparam logic [2:0] ST_PAYLOAD = 3'd4;

  // configuration
  logic             enable_q;
  logic [LEN_W-1:0] max_len_q;

  // frame state
  logic [2:0]             state_q, state_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [LEN_W-1:0]       idx_q, idx_d;
  logic [BYTE_W-1:0]      exp_sum_q, exp_sum_d;
  logic [BYTE_W-1:0]      run_sum_q, run_sum_d;
  logic [COUNT_WIDTH-1:0] good_q, good_d;
  logic [COUNT_WIDTH-1:0] bad_q, bad_d;

  // result register
  logic                                 out_valid_q;
  logic [spd_pkg::OUT_TDATA_W-1:0]      out_data_q, out_data_d;
  logic [spd_pkg::OUT_TUSER_W-1:0]      out_user_q, out_user_d;
  logic                                 out_last_q, out_last_d;

  logic                 in_fire;
  logic [BYTE_W-1:0]    rx;
  logic [LEN_W-1:0]     len_lo;
  logic [BYTE_W-1:0]    sum_next;
  logic                 last_byte;
  logic [spd_pkg::CLS_W-1:0] cls;
  logic [LEN_W-1:0]     idx_out;
  logic                 done;
  logic                 good;
  logic [31:0]          good_ext;
  logic [31:0]          bad_ext;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign rx        = s_axis_tdata_i;
  assign len_lo    = {len_q[LEN_W-1:BYTE_W], rx};
  assign sum_next  = run_sum_q + rx;
  assign last_byte = ({1'b0, idx_q} + (LEN_W+1)'(1)) >= {1'b0, len_q};

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    idx_d     = idx_q;
    exp_sum_d = exp_sum_q;
    run_sum_d = run_sum_q;
    good_d    = good_q;
    bad_d     = bad_q;
    cls       = spd_pkg::CLS_TEXT;
    idx_out   = '0;
    done      = 1'b0;
    good      = 1'b0;
    if (enable_q && (rx == spd_pkg::FRAME_START || state_q != ST_IDLE)) begin
      case (state_q)
        ST_IDLE: begin
          state_d = ST_LEN_HI;
          cls     = spd_pkg::CLS_HEADER;
        end
        ST_LEN_HI: begin
          state_d = ST_LEN_LO;
          len_d   = {rx, {BYTE_W{1'b0}}};
          cls     = spd_pkg::CLS_HEADER;
        end
        ST_LEN_LO: begin
          len_d = len_lo;
          if (len_lo <= max_len_q) begin
            state_d = ST_CSUM;
            cls     = spd_pkg::CLS_HEADER;
          end else begin
            state_d = ST_IDLE;
            cls     = spd_pkg::CLS_REJECTED;
          end
        end
        ST_CSUM: begin
          state_d   = ST_PAYLOAD;
          exp_sum_d = rx;
          run_sum_d = '0;
          idx_d     = '0;
          cls       = spd_pkg::CLS_HEADER;
        end
        ST_PAYLOAD: begin
          cls       = spd_pkg::CLS_PAYLOAD;
          idx_out   = idx_q;
          run_sum_d = sum_next;
          idx_d     = idx_q + LEN_W'(1);
          if (last_byte) begin
            // zero-length frames also end here, on their single byte
            done    = 1'b1;
            state_d = ST_IDLE;
            if (sum_next == exp_sum_q) begin
              good   = 1'b1;
              good_d = good_q + COUNT_WIDTH'(1);
            end else begin
              bad_d  = bad_q + COUNT_WIDTH'(1);
            end
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  assign good_ext = 32'(good_d);
  assign bad_ext  = 32'(bad_d);

  always_comb begin
    out_data_d = {bad_ext[spd_pkg::CNT_OUT_W-1:0], good_ext[spd_pkg::CNT_OUT_W-1:0],
                  len_d, idx_out, rx};
    out_user_d = {good, cls};
    out_last_d = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      max_len_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        spd_pkg::REG_PACKET_ENABLE: enable_q  <= cfg_data_i[0];
        spd_pkg::REG_MAX_LENGTH:    max_len_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      idx_q     <= '0;
      exp_sum_q <= '0;
      run_sum_q <= '0;
      good_q    <= '0;
      bad_q     <= '0;
    end else if (in_fire) begin
      state_q   <= state_d;
      len_q     <= len_d;
      idx_q     <= idx_d;
      exp_sum_q <= exp_sum_d;
      run_sum_q <= run_sum_d;
      good_q    <= good_d;
      bad_q     <= bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_done_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (m_axis_tuser_o[spd_pkg::CLS_W-1:0] == spd_pkg::CLS_PAYLOAD))
    else $error("frame end on a non-payload word");

  a_good_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[spd_pkg::CLS_W]) |-> m_axis_tlast_o)
    else $error("checksum_good without frame end");

  a_reject_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cls == spd_pkg::CLS_REJECTED) |=> (state_q == ST_IDLE))
    else $error("length reject did not return to idle");

  a_good_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && done && good) |=>
      (good_q == $past(good_q) + COUNT_WIDTH'(1) && bad_q == $past(bad_q)))
    else $error("good frame counter slip");

  a_bad_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && done && !good) |=>
      (bad_q == $past(bad_q) + COUNT_WIDTH'(1) && good_q == $past(good_q)))
    else $error("bad frame counter slip");

endmodule
